### hw/rtl/signed_int_to_decimal_ascii_defines.svh
// Assertion macros shared by the signed integer to decimal text block.
// Each macro checks on the rising edge of i_clk and is off during reset.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define SITDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The expression must never be true outside reset.
`define SITDA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

### hw/rtl/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Types and constants shared by the decimal text converter and its cells.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [3:0] t_bcd;

    typedef struct packed {
        logic clear;
        logic convert;
        logic shift;
    } t_cell_ctrl;

endpackage

### hw/rtl/sitda_digit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_digit_cell
// One decimal digit of the conversion chain: clears, adjusts and shifts in one
// binary bit per cycle, or passes its digit to the next higher cell.
// ----------------------------------------------------------------------------
module sitda_digit_cell (
    input  logic                  i_clk,
    input  sitda_pkg::t_cell_ctrl i_ctrl,
    input  logic                  i_carry,
    input  sitda_pkg::t_bcd       i_digit_below,
    output logic                  o_carry,
    output sitda_pkg::t_bcd       o_digit
);
    import sitda_pkg::*;

    t_bcd r_digit;
    t_bcd w_adj;

    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.convert) begin
            r_digit <= {w_adj[2:0], i_carry};
        end else if (i_ctrl.shift) begin
            r_digit <= i_digit_below;
        end
    end

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character a beat.
// ----------------------------------------------------------------------------
// The input channel takes one signed value per beat on i_valid, i_value
// while o_stall is low. The output channel gives one character per beat on
// o_valid, o_character, o_is_last; o_is_last marks the final character.
// A negative value starts with '-', and zero gives the single digit '0'.
// The magnitude runs through a chain of BCD digit cells, one binary bit per
// cycle. Leading zero digits are then dropped at one per cycle, after which
// one character leaves per cycle while the receiver does not stall. One item
// is in work at a time; the next one is taken while the last character still
// waits in the output register. When i_stall is high the output register
// holds its beat and the emission waits. Reset empties the output register
// and returns the block to idle, ready for a new value.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_character,
    output logic                   o_is_last
);
    import sitda_pkg::*;

    localparam int NDIG   = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state                   r_state;
    logic [VALUE_WIDTH-1:0]   r_mag;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;
    logic [LEFT_W-1:0]        r_left;
    logic                     r_out_valid;
    logic [7:0]               r_character;
    logic                     r_is_last;

    logic [VALUE_WIDTH-1:0]   w_raw;
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_load;
    logic                     w_more;
    t_cell_ctrl               w_ctrl;
    t_bcd                     w_top;
    t_bcd                     w_digit [NDIG];
    logic                     w_carry [NDIG];

    assign w_raw      = i_value;
    assign o_stall    = !i_rst_n || (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_load     = ((r_state == ST_SIGN) || (r_state == ST_EMIT)) && w_out_free;
    assign w_top      = w_digit[NDIG-1];
    assign w_more     = r_left > LEFT_W'(1);

    always_comb begin
        w_ctrl.clear   = w_accept;
        w_ctrl.convert = (r_state == ST_CONVERT);
        w_ctrl.shift   = ((r_state == ST_SKIP) && (w_top == 4'd0) && w_more) ||
                         ((r_state == ST_EMIT) && w_out_free);
    end

    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        sitda_digit_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_carry       ((k == 0) ? r_mag[VALUE_WIDTH-1] : w_carry[(k == 0) ? 0 : k-1]),
            .i_digit_below ((k == 0) ? 4'd0 : w_digit[(k == 0) ? 0 : k-1]),
            .o_carry       (w_carry[k]),
            .o_digit       (w_digit[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_neg   <= w_raw[VALUE_WIDTH-1];
                        r_mag   <= w_raw[VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
                        r_cnt   <= CNT_W'(VALUE_WIDTH - 1);
                        r_state <= ST_CONVERT;
                    end
                end
                ST_CONVERT: begin
                    r_mag <= r_mag << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_left  <= LEFT_W'(NDIG);
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if ((w_top == 4'd0) && w_more) begin
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_state <= r_neg ? ST_SIGN : ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    if (w_out_free) begin
                        r_character <= CHAR_MINUS;
                        r_is_last   <= 1'b0;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_character <= CHAR_ZERO + {4'b0000, w_top};
                        r_is_last   <= !w_more;
                        r_left      <= r_left - 1'b1;
                        if (!w_more) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_character;
    assign o_is_last   = r_is_last;

    `SITDA_ASSERT_NEVER(a_no_digit_overflow,
        (r_state == ST_CONVERT) && w_carry[NDIG-1],
        "Digit chain overflowed during conversion.")
    `SITDA_ASSERT(a_char_is_text,
        o_valid |-> ((o_character == CHAR_MINUS) ||
                     ((o_character >= CHAR_ZERO) && (o_character <= CHAR_ZERO + 8'd9))),
        "Output character is neither a digit nor a minus sign.")
    `SITDA_ASSERT_NEVER(a_minus_not_last,
        o_valid && (o_character == CHAR_MINUS) && o_is_last,
        "Minus sign flagged as the last character.")
    `SITDA_ASSERT(a_emit_has_digits,
        (r_state == ST_EMIT) |-> (r_left != '0),
        "Emission state entered with no digits left.")

endmodule

### tb/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Self-checking bench for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
// A queue of values feeds a clocked driver. Boundary and digit-count values
// come first, followed by random values of every length and sign. A clocked
// monitor compares each character beat against the text predicted at input
// acceptance. Both sides insert random idle bursts, except near the end of
// the run. The sender also waits for the text in flight to drain at a few
// points.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;
    import sitda_pkg::*;

    localparam int VW         = 32;
    localparam int RANDOM_CNT = 252;
    localparam int QUIET_CNT  = 40;
    localparam int TAIL_WAIT  = 80;
    localparam int CYCLE_MAX  = 300000;

    typedef struct {
        logic signed [VW-1:0] value;
        bit                   drain;
    } t_value_beat;

    typedef struct {
        logic [7:0] character;
        logic       is_last;
    } t_char_beat;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic signed [VW-1:0] i_value = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [7:0]           o_character;
    logic                 o_is_last;

    t_value_beat pending_values[$];
    t_char_beat  text_expected[$];
    t_char_beat  want;

    int errors        = 0;
    int values_sent   = 0;
    int negatives     = 0;
    int chars_checked = 0;
    int cycles        = 0;
    int send_idle     = 0;
    int recv_idle     = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VW)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_character(o_character),
        .o_is_last  (o_is_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void predict_text(input logic signed [VW-1:0] value);
        longint     mag;
        logic [7:0] digits[$];
        t_char_beat beat;
        mag = longint'(value);
        if (value < 0) begin
            mag = -mag;
            beat.character = CHAR_MINUS;
            beat.is_last   = 1'b0;
            text_expected.push_back(beat);
            negatives++;
        end
        do begin
            digits.push_front(CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        foreach (digits[k]) begin
            beat.character = digits[k];
            beat.is_last   = (k == digits.size() - 1);
            text_expected.push_back(beat);
        end
    endfunction

    function automatic logic signed [VW-1:0] random_value();
        int     n;
        longint lo;
        longint hi;
        longint v;
        case ($urandom_range(0, 3))
            0: v = longint'($signed($urandom));
            1: begin
                n  = $urandom_range(1, 10);
                lo = (n == 1) ? 0 : 10 ** (n - 1);
                hi = (n == 10) ? 64'd2147483647 : 10 ** n - 1;
                v  = lo + (longint'($urandom) % (hi - lo + 1));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            2: begin
                v = $urandom_range(0, 20);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    v = 64'd2147483647 - $urandom_range(0, 5);
                end else begin
                    v = -64'd2147483648 + $urandom_range(0, 5);
                end
            end
        endcase
        return v[VW-1:0];
    endfunction

    function automatic void queue_value(input logic signed [VW-1:0] value, input bit drain);
        t_value_beat item;
        item.value = value;
        item.drain = drain;
        pending_values.push_back(item);
    endfunction

    // Driver: a new beat is presented only once the current one is taken.
    always @(posedge i_clk) begin
        t_value_beat item;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_idle = 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_text(i_value);
                values_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_idle > 0) begin
                    send_idle--;
                    i_valid <= 1'b0;
                end else if (pending_values.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_values[0].drain && text_expected.size() != 0) begin
                    i_valid <= 1'b0;
                end else if (pending_values.size() > QUIET_CNT
                             && $urandom_range(0, 5) == 0) begin
                    send_idle = $urandom_range(1, 7) - 1;
                    i_valid   <= 1'b0;
                end else begin
                    item = pending_values.pop_front();
                    i_value <= item.value;
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks every accepted character beat and drives the stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            recv_idle = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (text_expected.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual char 0x%02h last %0b",
                             $time, o_character, o_is_last);
                    errors++;
                end else begin
                    want = text_expected.pop_front();
                    if (o_character !== want.character) begin
                        $display("%0t: character mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, want.character, o_character);
                        errors++;
                    end
                    if (o_is_last !== want.is_last) begin
                        $display("%0t: is_last mismatch, expected %0b, actual %0b",
                                 $time, want.is_last, o_is_last);
                        errors++;
                    end
                    chars_checked++;
                end
            end
            if (recv_idle > 0) begin
                recv_idle--;
                i_stall <= 1'b1;
            end else if (pending_values.size() > QUIET_CNT && $urandom_range(0, 4) == 0) begin
                recv_idle = $urandom_range(1, 7) - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("%0t: timeout with %0d values pending and %0d characters expected",
                     $time, pending_values.size(), text_expected.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        queue_value(0, 1'b0);
        queue_value(1, 1'b0);
        queue_value(-1, 1'b0);
        queue_value(9, 1'b0);
        queue_value(10, 1'b0);
        queue_value(-9, 1'b0);
        queue_value(-10, 1'b0);
        queue_value(99, 1'b0);
        queue_value(100, 1'b0);
        queue_value(32'sd2147483647, 1'b0);
        queue_value(-32'sd2147483647 - 1, 1'b0);
        queue_value(-32'sd2147483647, 1'b0);
        queue_value(32'sd1000000000, 1'b0);
        queue_value(-32'sd1000000000, 1'b0);
        queue_value(32'sd999999999, 1'b0);
        queue_value(32'sd123456789, 1'b0);
        queue_value(-32'sd987654321, 1'b0);
        queue_value(32'h5555_5555, 1'b0);
        queue_value(32'hAAAA_AAAA, 1'b0);
        queue_value(32'sd1000000009, 1'b1);
        for (int n = 0; n < RANDOM_CNT; n++) begin
            queue_value(random_value(), (n % 64) == 63);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() != 0 || i_valid || text_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Converted %0d values (%0d negative) into %0d checked characters,",
                 values_sent, negatives, chars_checked);
        $display("with random idle on both sides and drain pauses on the input.");
        if (errors == 0 && text_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d errors, %0d characters still expected", errors,
                     text_expected.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_digit_cell.sv
hw/rtl/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_test.sv
